>>> src/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg: rate-monotonic tick scheduler definitions
// Task count, field widths and register-map codes shared by the scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

   localparam int NUM_TASKS  = 4;   // scheduled tasks, 1 to 7
   localparam int CFG_TASKS  = 4;   // tasks that have cost/period registers
   localparam int MASK_TASKS = (NUM_TASKS < 4) ? NUM_TASKS : 4;
   localparam int TASK_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = $clog2(2 * CFG_TASKS);
   localparam int SEL_W      = CSR_IDX_W - 1;
   localparam int RUN_W      = 3;
   localparam int MASK_W     = 4;

   // low bit of the register index selects the field within a task
   localparam logic REG_COST   = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   localparam logic [RUN_W-1:0] RUN_IDLE = '0;

   typedef logic [DATA_W-1:0] data_type;

endpackage

>>> src/rate_monotonic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler: preemptive rate-monotonic scheduler
// One word per timer tick in, one scheduling decision per tick out.
// ----------------------------------------------------------------------------
// Each accepted request word is one timer tick. The tick is captured in an
// input register, from which a single pass of logic applies the
// releases of all tasks, picks the ready task with the shortest period (lower
// index wins ties), charges it one tick and loads the decision into the
// response register. A tick is taken every cycle while the response is not
// stalled; a response waits in its register for the consumer, with the
// input register holding one more tick behind it. Cost and period registers
// are to be written through the csr port only while no tick is in flight;
// the block does not enforce this. A period of zero disables a task.

module rate_monotonic_tick_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rmts_pkg::RUN_W-1:0]     rsp_running_task,
   output logic [rmts_pkg::MASK_W-1:0]    rsp_overrun_mask,
   input  logic                           csr_we,
   input  logic [rmts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmts_pkg::DATA_W-1:0]    csr_wdata
);
   import rmts_pkg::*;

   // configuration
   data_type cost_ff      [NUM_TASKS];
   data_type period_ff    [NUM_TASKS];

   // scheduler state
   data_type budget_ff    [NUM_TASKS];
   data_type countdown_ff [NUM_TASKS];
   data_type budget_rel   [NUM_TASKS];
   data_type budget_in    [NUM_TASKS];
   data_type countdown_in [NUM_TASKS];

   // input stage
   logic     s1_valid_ff;
   logic     s1_restart_ff;
   logic     s1_advance;
   logic     s1_fire;

   // output stage
   logic                rsp_valid_ff;
   logic [RUN_W-1:0]    running_ff;
   logic [MASK_W-1:0]   overrun_ff;
   logic [RUN_W-1:0]    running_in;
   logic [MASK_W-1:0]   overrun_in;

   logic                pick_found;
   logic [TASK_W-1:0]   pick_idx;
   data_type            pick_period;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_stall  = s1_valid_ff && !s1_advance;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = running_ff;
   assign rsp_overrun_mask = overrun_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (reset || i >= CFG_TASKS) begin
            cost_ff[i]   <= '0;
            period_ff[i] <= '0;
         end else if (csr_we && csr_index[CSR_IDX_W-1:1] == SEL_W'(i)) begin
            if (csr_index[0] == REG_PERIOD) begin
               period_ff[i] <= csr_wdata;
            end else if (csr_index[0] == REG_COST) begin
               cost_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // releases, priority pick and budget charge
   always_comb begin
      overrun_in  = '0;
      pick_found  = 1'b0;
      pick_idx    = '0;
      pick_period = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (period_ff[i] == '0) begin
            budget_rel[i]   = '0;
            countdown_in[i] = '0;
         end else if (s1_restart_ff || countdown_ff[i] == '0) begin
            budget_rel[i]   = cost_ff[i];
            countdown_in[i] = period_ff[i] - data_type'(1);
         end else begin
            budget_rel[i]   = budget_ff[i];
            countdown_in[i] = countdown_ff[i] - data_type'(1);
         end
      end
      // overrun: released while the previous job still had budget
      for (int i = 0; i < MASK_TASKS; i++) begin
         overrun_in[i] = (period_ff[i] != '0) && !s1_restart_ff &&
                         (countdown_ff[i] == '0) && (budget_ff[i] != '0);
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (period_ff[i] != '0 && budget_rel[i] != '0 &&
             (!pick_found || period_ff[i] < pick_period)) begin
            pick_found  = 1'b1;
            pick_idx    = TASK_W'(i);
            pick_period = period_ff[i];
         end
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (pick_found && pick_idx == TASK_W'(i)) begin
            budget_in[i] = budget_rel[i] - data_type'(1);
         end else begin
            budget_in[i] = budget_rel[i];
         end
      end
      running_in = pick_found ? (RUN_W'(pick_idx) + RUN_W'(1)) : RUN_IDLE;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         s1_restart_ff <= req_restart;
      end
   end

   // state update, once per tick
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (reset) begin
            budget_ff[i]    <= '0;
            countdown_ff[i] <= '0;
         end else if (s1_fire) begin
            budget_ff[i]    <= budget_in[i];
            countdown_ff[i] <= countdown_in[i];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_fire) begin
         running_ff <= running_in;
         overrun_ff <= overrun_in;
      end
   end

   // a processed tick always lands in the response register
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid)
      else $error("processed tick did not reach the response register");

   // the reported task exists
   a_run_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_running_task <= RUN_W'(NUM_TASKS)))
      else $error("running task out of range");

   // a disabled task never holds budget after a tick
   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_chk
      a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
         s1_fire && period_ff[g] == '0 |=> budget_ff[g] == '0 &&
                                           countdown_ff[g] == '0)
         else $error("disabled task kept state");
   end

endmodule
